[rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion converter
// Payload structs, CORDIC arctangent table and fixed-point constants.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen = 24;
  localparam int Iters = (CordicSteps < TableLen) ? CordicSteps : TableLen;

  localparam logic signed [33:0] KQ30 = 34'sd652032874;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_item_t;

  // one angle's CORDIC state: x, y and residual angle in Q4.30
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic neg_cos;
  } rot_t;

  // cosine and sine of one half angle, Q15
  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } sc_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

endpackage

[rtl/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined rotation-mode CORDIC for one half angle
// Folds the half angle into +-pi/2, runs one iteration per stage and rounds
// the cosine and sine to Q15. Stage enables come from the top level.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic clk,
  input  logic [e2q_pkg::Iters+1:0] en,
  input  logic signed [15:0] angle,
  output e2q_pkg::sc_t sc
);
  import e2q_pkg::*;

  rot_t st [Iters+1];
  logic signed [33:0] z0;
  logic signed [33:0] cx;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  assign z0 = 34'(angle) <<< 16;

  // fold into the CORDIC's range
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].x <= KQ30;
      st[0].y <= '0;
      if (z0 > HalfPiQ30) begin
        st[0].z <= PiQ30 - z0;
        st[0].neg_cos <= 1'b1;
      end else if (z0 < -HalfPiQ30) begin
        st[0].z <= -PiQ30 - z0;
        st[0].neg_cos <= 1'b1;
      end else begin
        st[0].z <= z0;
        st[0].neg_cos <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        st[i+1].neg_cos <= st[i].neg_cos;
        if (!st[i].z[33]) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - atan_q30(i);
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + atan_q30(i);
        end
      end
    end
  end

  assign cx = st[Iters].neg_cos ? -st[Iters].x : st[Iters].x;
  assign xr = (cx + 34'sd16384) >>> 15;
  assign yr = (st[Iters].y + 34'sd16384) >>> 15;

  // round to Q15
  always_ff @(posedge clk) begin
    if (en[Iters+1]) begin
      sc.c <= xr[17:0];
      sc.s <= yr[17:0];
    end
  end
endmodule

[rtl/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine: quaternion product tree
// Pair products, triple products, sums, then round and saturate to Q1.14.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic clk,
  input  logic [3:0] en,
  input  e2q_pkg::sc_t p,
  input  e2q_pkg::sc_t r,
  input  e2q_pkg::sc_t yw,
  output e2q_pkg::out_item_t q
);
  import e2q_pkg::*;

  logic signed [35:0] cycr, cysr, sycr, sysr;
  logic signed [17:0] cp1, sp1;
  logic signed [53:0] t0, t1, t2, t3, t4, t5, t6, t7;
  logic signed [54:0] sw, sx, sy, sz;

  function automatic logic signed [15:0] to_q14(input logic signed [54:0] v);
    logic signed [54:0] f;
    f = (v + (55'sd1 <<< 30)) >>> 31;
    if (f > 55'(OneQ14)) return OneQ14;
    if (f < -55'(OneQ14)) return -OneQ14;
    return f[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cycr <= yw.c * r.c;
      cysr <= yw.c * r.s;
      sycr <= yw.s * r.c;
      sysr <= yw.s * r.s;
      cp1 <= p.c;
      sp1 <= p.s;
    end
    if (en[1]) begin
      t0 <= cycr * cp1;
      t1 <= sysr * sp1;
      t2 <= cysr * cp1;
      t3 <= sycr * sp1;
      t4 <= cycr * sp1;
      t5 <= sysr * cp1;
      t6 <= sycr * cp1;
      t7 <= cysr * sp1;
    end
    if (en[2]) begin
      sw <= 55'(t0) + 55'(t1);
      sx <= 55'(t2) - 55'(t3);
      sy <= 55'(t4) + 55'(t5);
      sz <= 55'(t6) - 55'(t7);
    end
    if (en[3]) begin
      q.quat_w <= to_q14(sw);
      q.quat_x <= to_q14(sx);
      q.quat_y <= to_q14(sy);
      q.quat_z <= to_q14(sz);
    end
  end
endmodule

[rtl/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion: Euler angles to unit quaternion
// Three CORDIC pipelines feed a product tree; valid bits ride alongside.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | into      | in_item_t  (pitch, roll, yaw, Q3.13)
// out     | out of    | out_item_t (w, x, y, z, Q1.14)
//
// One item per cycle sustained while out_ready stays high. The stages are
// a fold stage, one CORDIC iteration per stage, a rounding stage
// and four product stages.
// Reset clears only the valid bits; data registers carry no reset.
// A stall holds each full stage whose successor cannot advance (bubbles are squeezed out).
module euler_to_quaternion (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  e2q_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output e2q_pkg::out_item_t out_data
);
  import e2q_pkg::*;

  localparam int Depth = Iters + 6;

  logic [Depth-1:0] vld;
  logic [Depth-1:0] adv;
  sc_t scp, scr, scy;

  // stage k advances when it can hand on or is empty
  always_comb begin
    adv[Depth-1] = !vld[Depth-1] || out_ready;
    for (int k = Depth - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < Depth; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  e2q_cordic u_p (.clk, .en(adv[Iters+1:0]), .angle(in_data.pitch_angle), .sc(scp));
  e2q_cordic u_r (.clk, .en(adv[Iters+1:0]), .angle(in_data.roll_angle), .sc(scr));
  e2q_cordic u_y (.clk, .en(adv[Iters+1:0]), .angle(in_data.yaw_angle), .sc(scy));

  e2q_combine u_comb (
    .clk,
    .en(adv[Depth-1:Iters+2]),
    .p(scp),
    .r(scr),
    .yw(scy),
    .q(out_data)
  );

  // a full last stage that is not taken must stay full
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");
endmodule
